// File: hw/rtl/fdep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdep_pkg
// Types, codes and constants shared by the directory entry parser files.
// ----------------------------------------------------------------------------
package fdep_pkg;

    localparam logic [7:0]  BYTE_END      = 8'h00;
    localparam logic [7:0]  BYTE_DELETED  = 8'hE5;
    localparam logic [7:0]  ATTR_LFN      = 8'h0F;
    localparam logic [7:0]  ATTR_VOLUME   = 8'h08;
    localparam logic [7:0]  LFN_LAST_FLAG = 8'h40;
    localparam logic [4:0]  LFN_SEQ_MASK  = 5'h1F;
    localparam logic [15:0] UCS_NONE      = 16'hFFFF;
    localparam logic [15:0] UCS_ZERO      = 16'h0000;
    localparam logic [15:0] ASCII_LIMIT   = 16'h0080;
    localparam logic [8:0]  LFN_CHARS     = 9'd13;
    localparam logic [3:0]  LFN_LAST_IDX  = 4'd12;
    localparam logic [4:0]  SLOT_MAX      = 5'd20;
    localparam logic [15:0] ORD_MAX       = 16'hFFFF;
    localparam logic [7:0]  CHAR_SUBST    = 8'h3F;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_NUL      = 8'h00;
    localparam logic [4:0]  ENTRY_LAST    = 5'd31;
    localparam int          MAX_RESULTS   = 63;
    localparam int          SHORT_BYTES   = 11;

    typedef struct packed {
        logic [7:0] entry_byte;
        logic       start_dir;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  name_char;
        logic        name_last;
        logic [7:0]  attr_bits;
        logic [31:0] first_cluster;
        logic [31:0] file_size;
        logic [15:0] entry_ordinal;
        logic [4:0]  long_slots;
        logic        dir_end;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_END,
        CLS_CLEAR,
        CLS_LFN,
        CLS_FILE
    } t_entry_class;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_CLASSIFY,
        S_LFN_LO,
        S_LFN_HI,
        S_SCAN,
        S_EMIT,
        S_END
    } t_state;

    typedef struct packed {
        logic capture;
        logic classify;
        logic set_ended;
        logic clear_long;
        logic lfn_start;
        logic lfn_lo;
        logic lfn_hi;
        logic idx_clr;
        logic idx_inc;
        logic scan_latch;
        logic load_char;
        logic load_end;
    } t_dp_cmd;

    typedef struct packed {
        logic         full_entry;
        t_entry_class cls;
        logic         lfn_go;
        logic         lfn_more;
        logic         scan_stop;
        logic         long_empty;
        logic         short_empty;
        logic         emit_last;
        logic         out_free;
    } t_dp_sts;

    // byte offset of each character of a long-name slot
    function automatic logic [4:0] lfn_pos(input logic [3:0] i);
        logic [4:0] p;
        case (i)
            4'd0:    p = 5'd1;
            4'd1:    p = 5'd3;
            4'd2:    p = 5'd5;
            4'd3:    p = 5'd7;
            4'd4:    p = 5'd9;
            4'd5:    p = 5'd14;
            4'd6:    p = 5'd16;
            4'd7:    p = 5'd18;
            4'd8:    p = 5'd20;
            4'd9:    p = 5'd22;
            4'd10:   p = 5'd24;
            4'd11:   p = 5'd28;
            4'd12:   p = 5'd30;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/fdep_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdep_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface fdep_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/fat_dir_entry_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_dir_entry_parser_unit
// FAT directory byte stream in, one beat per name character out.
// ----------------------------------------------------------------------------
// Directory bytes are taken one per cycle while the unit collects an entry;
// after the 32nd byte it classifies the entry. A long-name slot then reads
// both bytes of each stored UCS-2 character through the single read port
// of the entry store, up to 13 characters. A file entry scans the long-name
// store character by character, then sends one result beat per cycle while
// the output is taken; a short 8.3 name goes to output once the scan finds
// the long-name store empty. Deleted, label and dot entries go from the
// classify state straight back to collection. The end-of-directory entry
// gives one beat with dir_end set, after which bytes are taken and dropped
// until start_dir marks a new directory. No clearing pass runs after reset:
// the long-name store carries a valid bit per entry. Input is not taken while
// a name is being written out; a finished last beat may wait in the output
// register while collection of the next entry goes on.
// ----------------------------------------------------------------------------
module fat_dir_entry_parser_unit
    import fdep_pkg::*;
#(
    parameter int NAME_MAX = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fdep_stream_if.sink                     i_in,
    fdep_stream_if.source                   o_out
);

    t_dp_cmd   dp_cmd;
    t_dp_sts   dp_sts;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    fdep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    fdep_datapath #(
        .NAME_MAX (NAME_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;

    // a result beat is only loaded into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load_char || dp_cmd.load_end) |-> dp_sts.out_free)
        else $error("result loaded over a pending beat");

    // no input while the name is being written out
    a_emit_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load_char || dp_cmd.load_end) |-> !i_in.ready)
        else $error("input taken during name output");

    // a completed entry stops collection for classification
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.capture && dp_sts.full_entry) |=> (!i_in.ready && dp_cmd.classify))
        else $error("entry not classified after its last byte");

    // the end beat is always a single final beat
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.dir_end) |-> o_out.data.name_last)
        else $error("end beat without name_last");

endmodule

// File: hw/rtl/fdep_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdep_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fdep_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdep_ctrl
// Sequencer: byte collection, classification, long-name store, name output.
// ----------------------------------------------------------------------------
module fdep_ctrl
    import fdep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_COLLECT: begin
                if (i_in_valid && i_sts.full_entry) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                case (i_sts.cls)
                    CLS_END:   n_state = S_END;
                    CLS_CLEAR: n_state = S_COLLECT;
                    CLS_LFN:   n_state = i_sts.lfn_go ? S_LFN_LO : S_COLLECT;
                    CLS_FILE:  n_state = S_SCAN;
                    default:   n_state = S_COLLECT;
                endcase
            end
            S_LFN_LO: n_state = S_LFN_HI;
            S_LFN_HI: begin
                n_state = i_sts.lfn_more ? S_LFN_LO : S_COLLECT;
            end
            S_SCAN: begin
                if (i_sts.scan_stop) begin
                    n_state = (i_sts.long_empty && i_sts.short_empty) ? S_COLLECT : S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = S_COLLECT;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                case (i_sts.cls)
                    CLS_END:   o_cmd.set_ended = 1'b1;
                    CLS_CLEAR: o_cmd.clear_long = 1'b1;
                    CLS_LFN: begin
                        o_cmd.lfn_start = 1'b1;
                        o_cmd.idx_clr   = 1'b1;
                    end
                    CLS_FILE:  o_cmd.idx_clr = 1'b1;
                    default:   o_cmd.classify = 1'b1;
                endcase
            end
            S_LFN_LO: o_cmd.lfn_lo = 1'b1;
            S_LFN_HI: begin
                o_cmd.lfn_hi  = 1'b1;
                o_cmd.idx_inc = i_sts.lfn_more;
            end
            S_SCAN: begin
                if (i_sts.scan_stop) begin
                    o_cmd.scan_latch = 1'b1;
                    o_cmd.idx_clr    = 1'b1;
                    // nothing to print, still drops the long name
                    o_cmd.clear_long = i_sts.long_empty && i_sts.short_empty;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_char = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clear_long = 1'b1;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_END: begin
                o_cmd.load_end = i_sts.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/fdep_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdep_datapath
// Entry store, long-name store, field registers, name formatting, output beat.
// ----------------------------------------------------------------------------
module fdep_datapath
    import fdep_pkg::*;
#(
    parameter int NAME_MAX = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    localparam int LN_DEPTH = NAME_MAX - 1;
    localparam int LA       = $clog2(LN_DEPTH);
    localparam int IW       = $clog2(LN_DEPTH + 1);
    localparam int LEN_LIM  = (LN_DEPTH > MAX_RESULTS) ? MAX_RESULTS : LN_DEPTH;

    logic [4:0]          r_pos;
    logic                r_ended;
    logic [15:0]         r_ord;
    logic [15:0]         r_cur_ord;
    logic [4:0]          r_slots;
    logic [LN_DEPTH-1:0] r_ln_vld;
    logic [LN_DEPTH-1:0] n_ln_vld;
    logic                r_rd_vld;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       n_idx;
    logic                r_hi;
    logic                n_hi;
    logic [7:0]          r_lo;
    logic [IW-1:0]       r_len;
    logic                r_src_short;
    logic [7:0]          r_sn [SHORT_BYTES];
    logic [7:0]          r_attr;
    logic [15:0]         r_clus_hi;
    logic [15:0]         r_clus_lo;
    logic [31:0]         r_size;
    logic                r_out_valid;
    t_out_item           r_out;

    // ---------------- byte capture ----------------
    logic       start;
    logic [4:0] eff_pos;
    logic       take;

    assign start   = i_cmd.capture && i_in_data.start_dir;
    assign eff_pos = i_in_data.start_dir ? 5'd0 : r_pos;
    assign take    = i_cmd.capture && (i_in_data.start_dir || !r_ended);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ended <= 1'b0;
        end else begin
            if (take) begin
                r_pos <= (eff_pos == ENTRY_LAST) ? 5'd0 : eff_pos + 5'd1;
            end
            if (start) begin
                r_ended <= 1'b0;
            end else if (i_cmd.set_ended) begin
                r_ended <= 1'b1;
            end
        end
    end

    // fixed-offset fields held in registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (eff_pos < 5'(SHORT_BYTES)) begin
                r_sn[eff_pos[3:0]] <= i_in_data.entry_byte;
            end
            case (eff_pos)
                5'd11:   r_attr          <= i_in_data.entry_byte;
                5'd20:   r_clus_hi[7:0]  <= i_in_data.entry_byte;
                5'd21:   r_clus_hi[15:8] <= i_in_data.entry_byte;
                5'd26:   r_clus_lo[7:0]  <= i_in_data.entry_byte;
                5'd27:   r_clus_lo[15:8] <= i_in_data.entry_byte;
                5'd28:   r_size[7:0]     <= i_in_data.entry_byte;
                5'd29:   r_size[15:8]    <= i_in_data.entry_byte;
                5'd30:   r_size[23:16]   <= i_in_data.entry_byte;
                5'd31:   r_size[31:24]   <= i_in_data.entry_byte;
                default: r_attr          <= r_attr;
            endcase
        end
    end

    // ---------------- ordinal and slot count ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord   <= '0;
            r_slots <= '0;
        end else begin
            if (start) begin
                r_ord <= '0;
            end else if (i_cmd.classify && r_ord != ORD_MAX) begin
                r_ord <= r_ord + 16'd1;
            end
            if (start || i_cmd.clear_long) begin
                r_slots <= '0;
            end else if (i_cmd.lfn_start && r_slots < SLOT_MAX) begin
                r_slots <= r_slots + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.classify) begin
            r_cur_ord <= r_ord;
        end
    end

    // ---------------- classification ----------------
    t_entry_class cls;
    logic [4:0]   seq;
    logic [8:0]   base;

    always_comb begin
        if (r_sn[0] == BYTE_END) begin
            cls = CLS_END;
        end else if (r_sn[0] == BYTE_DELETED) begin
            cls = CLS_CLEAR;
        end else if (r_attr == ATTR_LFN) begin
            cls = CLS_LFN;
        end else if ((r_attr & ATTR_VOLUME) != 8'h00 || r_sn[0] == CHAR_DOT) begin
            cls = CLS_CLEAR;
        end else begin
            cls = CLS_FILE;
        end
    end

    assign seq  = r_sn[0][4:0] & LFN_SEQ_MASK;
    assign base = ({4'd0, seq} - 9'd1) * LFN_CHARS;

    // ---------------- index and read addresses ----------------
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
        n_hi = r_hi;
        if (i_cmd.lfn_start || i_cmd.lfn_hi) begin
            n_hi = 1'b0;
        end else if (i_cmd.lfn_lo) begin
            n_hi = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_hi  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_hi  <= n_hi;
        end
    end

    // entry store: one read per cycle, address follows the next index
    logic [4:0] er_raddr;
    logic [7:0] er_rdata;

    assign er_raddr = lfn_pos(n_idx[3:0]) + {4'd0, n_hi};

    fdep_ram #(
        .WIDTH (8),
        .DEPTH (32)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (eff_pos),
        .i_wdata (i_in_data.entry_byte),
        .i_raddr (er_raddr),
        .o_rdata (er_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lfn_lo) begin
            r_lo <= er_rdata;
        end
    end

    // ---------------- long-name store ----------------
    logic [15:0]   lfn_ch;
    logic          lfn_term;
    logic [7:0]    lfn_char;
    logic [9:0]    ln_waddr_full;
    logic [LA-1:0] ln_waddr;
    logic [LA-1:0] ln_raddr;
    logic [7:0]    ln_rdata;
    logic [7:0]    ln_char;

    assign lfn_ch        = {er_rdata, r_lo};
    assign lfn_term      = (lfn_ch == UCS_ZERO) || (lfn_ch == UCS_NONE);
    assign lfn_char      = lfn_term ? CHAR_NUL :
                           (lfn_ch < ASCII_LIMIT) ? lfn_ch[7:0] : CHAR_SUBST;
    assign ln_waddr_full = {1'b0, base} + 10'(r_idx);
    assign ln_waddr      = ln_waddr_full[LA-1:0];
    assign ln_raddr      = (n_idx < IW'(LN_DEPTH)) ? n_idx[LA-1:0] : '0;

    fdep_ram #(
        .WIDTH (8),
        .DEPTH (LN_DEPTH)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.lfn_hi),
        .i_waddr (ln_waddr),
        .i_wdata (lfn_char),
        .i_raddr (ln_raddr),
        .o_rdata (ln_rdata)
    );

    // entries not written since the last clear read as zero
    always_comb begin
        n_ln_vld = r_ln_vld;
        if (start || (i_cmd.lfn_start && (r_sn[0] & LFN_LAST_FLAG) != 8'h00)) begin
            n_ln_vld = '0;
        end else if (i_cmd.clear_long) begin
            n_ln_vld[0] = 1'b0;
        end
        if (i_cmd.lfn_hi) begin
            n_ln_vld[ln_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_vld <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_ln_vld <= n_ln_vld;
            r_rd_vld <= r_ln_vld[ln_raddr];
        end
    end

    assign ln_char = r_rd_vld ? ln_rdata : CHAR_NUL;

    // ---------------- name length ----------------
    logic [3:0]    blen;
    logic [1:0]    elen;
    logic          bfound;
    logic          efound;
    logic [3:0]    short_len;
    logic [IW-1:0] long_len;
    logic [IW-1:0] long_len_clip;
    logic          scan_stop;
    logic          long_empty;

    always_comb begin
        blen   = 4'd8;
        bfound = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!bfound && (r_sn[k] == CHAR_SPACE || r_sn[k] == CHAR_NUL)) begin
                blen   = 4'(k);
                bfound = 1'b1;
            end
        end
        elen   = 2'd3;
        efound = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (!efound && (r_sn[8+k] == CHAR_SPACE || r_sn[8+k] == CHAR_NUL)) begin
                elen   = 2'(k);
                efound = 1'b1;
            end
        end
    end

    assign short_len     = blen + ((elen != 2'd0) ? 4'd1 + {2'd0, elen} : 4'd0);
    assign scan_stop     = (ln_char == CHAR_NUL) ||
                           (({1'b0, r_idx} + 1'b1) >= (IW+1)'(LN_DEPTH));
    assign long_len      = (ln_char != CHAR_NUL) ? r_idx + 1'b1 : r_idx;
    assign long_len_clip = (long_len > IW'(LEN_LIM)) ? IW'(LEN_LIM) : long_len;
    assign long_empty    = (ln_char == CHAR_NUL) && (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_latch) begin
            r_len       <= long_empty ? IW'(short_len) : long_len_clip;
            r_src_short <= long_empty;
        end
    end

    // ---------------- character select ----------------
    logic [3:0] sk;
    logic [3:0] ext_sel;
    logic [7:0] short_char;
    logic [7:0] emit_char;
    logic       emit_last;

    assign sk      = r_idx[3:0];
    assign ext_sel = sk + 4'd7 - blen;

    always_comb begin
        if (sk < blen) begin
            short_char = r_sn[sk];
        end else if (sk == blen) begin
            short_char = CHAR_DOT;
        end else if (ext_sel < 4'(SHORT_BYTES)) begin
            short_char = r_sn[ext_sel];
        end else begin
            short_char = CHAR_NUL;
        end
    end

    assign emit_char = r_src_short ? short_char : ln_char;
    assign emit_last = ({1'b0, r_idx} + 1'b1) == {1'b0, r_len};

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_char || i_cmd.load_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_out.name_char     <= emit_char;
            r_out.name_last     <= emit_last;
            r_out.attr_bits     <= r_attr;
            r_out.first_cluster <= {r_clus_hi, r_clus_lo};
            r_out.file_size     <= r_size;
            r_out.entry_ordinal <= r_cur_ord;
            r_out.long_slots    <= r_slots;
            r_out.dir_end       <= 1'b0;
        end else if (i_cmd.load_end) begin
            r_out.name_char     <= CHAR_NUL;
            r_out.name_last     <= 1'b1;
            r_out.attr_bits     <= '0;
            r_out.first_cluster <= '0;
            r_out.file_size     <= '0;
            r_out.entry_ordinal <= r_cur_ord;
            r_out.long_slots    <= '0;
            r_out.dir_end       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- status ----------------
    assign o_sts.full_entry  = take && (eff_pos == ENTRY_LAST);
    assign o_sts.cls         = cls;
    assign o_sts.lfn_go      = (seq != 5'd0) && (base < 9'(LN_DEPTH));
    assign o_sts.lfn_more    = !lfn_term && (r_idx[3:0] != LFN_LAST_IDX) &&
                               ((ln_waddr_full + 10'd1) < 10'(LN_DEPTH));
    assign o_sts.scan_stop   = scan_stop;
    assign o_sts.long_empty  = long_empty;
    assign o_sts.short_empty = (short_len == 4'd0);
    assign o_sts.emit_last   = emit_last;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

endmodule

// File: dv/fdep_dir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdep_dir_checker
// Watches both channels of the directory entry parser, rebuilds the name
// beats that each accepted byte should produce and compares them in order.
// ----------------------------------------------------------------------------
module fdep_dir_checker
    import fdep_pkg::*;
#(
    parameter int NAME_MAX = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fdep_stream_if i_in_mon,
    fdep_stream_if i_out_mon,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int SLOT_CHARS = 13;
    // byte offset of each character within a long-name slot, entry 0 in the low bits
    localparam logic [64:0] SLOT_OFS = {5'd30, 5'd28, 5'd24, 5'd22, 5'd20, 5'd18,
                                        5'd16, 5'd14, 5'd9, 5'd7, 5'd5, 5'd3, 5'd1};

    logic [7:0]  ent_q [32];
    logic [4:0]  pos_q;
    logic [7:0]  lname_q [NAME_MAX];
    logic [15:0] ord_q;
    logic [4:0]  slots_q;
    logic        ended_q;
    t_out_item   name_beats_q [$];
    int          fails;

    task automatic reset_model();
        int i;
        for (i = 0; i < 32; i++) ent_q[i] = 8'h00;
        for (i = 0; i < NAME_MAX; i++) lname_q[i] = 8'h00;
        pos_q   = '0;
        ord_q   = '0;
        slots_q = '0;
        ended_q = 1'b0;
        name_beats_q.delete();
    endtask

    task automatic place_slot();
        int          i;
        int          base;
        logic [4:0]  seq;
        logic [4:0]  p;
        logic [15:0] ch;
        seq = ent_q[0][4:0];
        if (ent_q[0][6]) begin
            for (i = 0; i < NAME_MAX; i++) lname_q[i] = 8'h00;
        end
        if (seq == 5'd0) return;
        base = (int'(seq) - 1) * SLOT_CHARS;
        for (i = 0; i < SLOT_CHARS; i++) begin
            if (base + i + 1 >= NAME_MAX) break;
            p  = SLOT_OFS[i*5 +: 5];
            ch = {ent_q[p + 5'd1], ent_q[p]};
            if (ch == UCS_ZERO || ch == UCS_NONE) begin
                lname_q[base + i] = CHAR_NUL;
                break;
            end
            lname_q[base + i] = (ch < ASCII_LIMIT) ? ch[7:0] : CHAR_SUBST;
        end
    endtask

    // one accepted byte: update the parser state and queue the beats it causes
    task automatic parse_byte(input logic [7:0] b, input logic start);
        logic [7:0]  nm [NAME_MAX];
        int          len;
        int          lim;
        int          i;
        logic [15:0] ord;
        logic [7:0]  attr;
        logic [31:0] clus;
        logic [31:0] size;
        t_out_item   r;
        if (start) begin
            for (i = 0; i < NAME_MAX; i++) lname_q[i] = 8'h00;
            ord_q   = '0;
            slots_q = '0;
            ended_q = 1'b0;
            pos_q   = '0;
        end
        if (ended_q) return;
        ent_q[pos_q] = b;
        if (pos_q != 5'd31) begin
            pos_q = pos_q + 5'd1;
            return;
        end
        pos_q = '0;
        ord   = ord_q;
        if (ord_q != ORD_MAX) ord_q = ord_q + 16'd1;
        attr = ent_q[11];

        if (ent_q[0] == BYTE_END) begin
            ended_q         = 1'b1;
            r               = '0;
            r.name_last     = 1'b1;
            r.entry_ordinal = ord;
            r.dir_end       = 1'b1;
            name_beats_q.push_back(r);
            return;
        end
        if (ent_q[0] == BYTE_DELETED) begin
            lname_q[0] = CHAR_NUL;
            slots_q    = '0;
            return;
        end
        if (attr == ATTR_LFN) begin
            place_slot();
            if (slots_q < SLOT_MAX) slots_q = slots_q + 5'd1;
            return;
        end
        if ((attr & ATTR_VOLUME) != 8'h00 || ent_q[0] == CHAR_DOT) begin
            lname_q[0] = CHAR_NUL;
            slots_q    = '0;
            return;
        end

        len = 0;
        if (lname_q[0] != CHAR_NUL) begin
            for (i = 0; i < NAME_MAX - 1; i++) begin
                if (lname_q[i] == CHAR_NUL) break;
                nm[len] = lname_q[i];
                len     = len + 1;
            end
        end else begin
            for (i = 0; i < 8; i++) begin
                if (ent_q[i] == CHAR_SPACE || ent_q[i] == CHAR_NUL) break;
                nm[len] = ent_q[i];
                len     = len + 1;
            end
            if (ent_q[8] != CHAR_SPACE && ent_q[8] != CHAR_NUL) begin
                nm[len] = CHAR_DOT;
                len     = len + 1;
                for (i = 8; i < 11; i++) begin
                    if (ent_q[i] == CHAR_SPACE || ent_q[i] == CHAR_NUL) break;
                    nm[len] = ent_q[i];
                    len     = len + 1;
                end
            end
        end
        lim = (NAME_MAX - 1 > MAX_RESULTS) ? MAX_RESULTS : NAME_MAX - 1;
        if (len > lim) len = lim;
        lname_q[0] = CHAR_NUL;

        clus = {ent_q[21], ent_q[20], ent_q[27], ent_q[26]};
        size = {ent_q[31], ent_q[30], ent_q[29], ent_q[28]};
        for (i = 0; i < len; i++) begin
            r.name_char     = nm[i];
            r.name_last     = (i == len - 1);
            r.attr_bits     = attr;
            r.first_cluster = clus;
            r.file_size     = size;
            r.entry_ordinal = ord;
            r.long_slots    = slots_q;
            r.dir_end       = 1'b0;
            name_beats_q.push_back(r);
        end
        slots_q = '0;
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        logic      bad;
        if (name_beats_q.size() == 0) begin
            fails = fails + 1;
            if (fails <= 10)
                $display("%0t: unexpected beat char %h last %b ord %0d end %b",
                         $time, got.name_char, got.name_last, got.entry_ordinal, got.dir_end);
            return;
        end
        want = name_beats_q.pop_front();
        bad  = (got.name_char !== want.name_char) || (got.name_last !== want.name_last) ||
               (got.attr_bits !== want.attr_bits) ||
               (got.first_cluster !== want.first_cluster) ||
               (got.file_size !== want.file_size) ||
               (got.entry_ordinal !== want.entry_ordinal) ||
               (got.long_slots !== want.long_slots) || (got.dir_end !== want.dir_end);
        if (bad) begin
            fails = fails + 1;
            if (fails <= 10) begin
                $display("%0t: beat mismatch", $time);
                $display("  expected char %h last %b attr %h clus %h size %h ord %0d slots %0d end %b",
                         want.name_char, want.name_last, want.attr_bits, want.first_cluster,
                         want.file_size, want.entry_ordinal, want.long_slots, want.dir_end);
                $display("  actual   char %h last %b attr %h clus %h size %h ord %0d slots %0d end %b",
                         got.name_char, got.name_last, got.attr_bits, got.first_cluster,
                         got.file_size, got.entry_ordinal, got.long_slots, got.dir_end);
            end
        end
    endtask

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            // a result beat always belongs to an earlier byte, so check before predicting
            if (i_out_mon.valid && i_out_mon.ready) check_beat(i_out_mon.data);
            if (i_in_mon.valid && i_in_mon.ready)
                parse_byte(i_in_mon.data.entry_byte, i_in_mon.data.start_dir);
        end
        o_fail_count <= fails;
        o_pending    <= name_beats_q.size();
    end

endmodule

// File: dv/fat_dir_entry_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_dir_entry_parser_unit_tb
// Feeds directory byte streams into the parser: directed entries for the
// name forms and clearing rules, then random directories built from
// long-name chains with file entries, short files, cleared entries, noise, restarts and end markers.
// ----------------------------------------------------------------------------
module fat_dir_entry_parser_unit_tb
    import fdep_pkg::*;
;

    localparam int NAME_MAX     = 64;
    localparam int RAND_ENTRIES = 200;
    localparam int STALL_LIMIT  = 1500;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;

    fdep_stream_if #(.T(t_in_item))  in_ch ();
    fdep_stream_if #(.T(t_out_item)) out_ch ();

    int         fail_count;
    int         pending;
    int         stuck_cycles;
    int         entries_sent;
    bit         calm;
    bit         restart_next;
    logic [7:0] ent [32];

    fat_dir_entry_parser_unit #(
        .NAME_MAX (NAME_MAX)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fdep_dir_checker #(
        .NAME_MAX (NAME_MAX)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 21);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic st);
        while (take_break()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data.entry_byte <= b;
        in_ch.data.start_dir  <= st;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++) begin
            send_byte(ent[i], (i == 0) && restart_next);
            if (i == 0) restart_next = 1'b0;
        end
        if (nbytes == 32) begin
            entries_sent = entries_sent + 1;
            if (ent[0] == BYTE_END) restart_next = 1'b1;
        end
    endtask

    task automatic fill_noise();
        int i;
        for (i = 0; i < 32; i++) ent[i] = $urandom_range(255);
    endtask

    task automatic set_meta(input logic [7:0] attr, input logic [31:0] clus,
                            input logic [31:0] size);
        ent[11] = attr;
        ent[20] = clus[23:16];
        ent[21] = clus[31:24];
        ent[26] = clus[7:0];
        ent[27] = clus[15:8];
        ent[28] = size[7:0];
        ent[29] = size[15:8];
        ent[30] = size[23:16];
        ent[31] = size[31:24];
    endtask

    function automatic logic [7:0] name_byte(input bit lead);
        logic [7:0] v;
        do v = $urandom_range(1, 255);
        while (v == CHAR_SPACE || (lead && (v == BYTE_DELETED || v == CHAR_DOT)));
        return v;
    endfunction

    function automatic logic [15:0] slot_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return $urandom_range(1, 127);
        if (pick < 85) return $urandom_range(128, 255);
        return $urandom_range(16'h0100, 16'hFFFE);
    endfunction

    task automatic make_plain(input logic [7:0] first, input logic [7:0] attr);
        fill_noise();
        ent[0]  = first;
        ent[11] = attr;
    endtask

    // name bytes up to the given lengths, a space or zero stop, then leftover junk
    task automatic make_short(input int base_len, input int ext_len);
        int i;
        fill_noise();
        for (i = 0; i < 8; i++) begin
            if (i < base_len) ent[i] = name_byte(i == 0);
            else if (i == 0) ent[i] = CHAR_SPACE;
            else if (i == base_len) ent[i] = $urandom_range(1) ? CHAR_SPACE : CHAR_NUL;
        end
        for (i = 0; i < 3; i++) begin
            if (i < ext_len) ent[8 + i] = name_byte(0);
            else if (i == ext_len) ent[8 + i] = $urandom_range(1) ? CHAR_SPACE : CHAR_NUL;
        end
        ent[11] = $urandom_range(255) & ~ATTR_VOLUME;
    endtask

    task automatic make_slot(input logic [7:0] seq_byte, input int nchars);
        int          i;
        logic [15:0] ch;
        logic [4:0]  p;
        fill_noise();
        ent[0]  = seq_byte;
        ent[11] = ATTR_LFN;
        for (i = 0; i < 13; i++) begin
            p = lfn_pos(i[3:0]);
            if (i < nchars) ch = slot_char();
            else if (i == nchars || $urandom_range(3) != 0)
                ch = $urandom_range(1) ? UCS_ZERO : UCS_NONE;
            else ch = $urandom_range(16'hFFFF);
            ent[p]        = ch[7:0];
            ent[p + 5'd1] = ch[15:8];
        end
    endtask

    // long-name chain in the usual descending order, first slot flagged
    task automatic send_slots(input int n, input int last_chars, input bit broken);
        int         s;
        logic [7:0] seq;
        for (s = n; s >= 1; s--) begin
            seq = s[7:0] | ((s == n) ? LFN_LAST_FLAG : 8'h00);
            if (broken && $urandom_range(2) == 0) seq = $urandom_range(255);
            make_slot(seq, (s == n) ? last_chars : 13);
            send_bytes(32);
        end
    endtask

    task automatic send_short_file();
        make_short($urandom_range(0, 8), $urandom_range(0, 3));
        if ($urandom_range(9) == 0) ent[0] = name_byte(1);
        send_bytes(32);
    endtask

    task automatic send_dir_end(input int junk);
        int j;
        make_plain(BYTE_END, $urandom_range(255));
        send_bytes(32);
        for (j = 0; j < junk; j++) send_byte($urandom_range(255), 1'b0);
    endtask

    initial begin
        int k;
        int pick;
        int rand_start;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        calm           = 1'b0;
        restart_next   = 1'b0;
        entries_sent   = 0;
        stuck_cycles   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short names at the field extremes
        make_short(8, 3);
        ent[1]  = 8'hFF;
        ent[10] = 8'h80;
        set_meta(8'hF7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bytes(32);
        make_short(1, 0);
        set_meta(8'h00, 32'h0, 32'h0);
        send_bytes(32);
        make_short(0, 3);
        send_bytes(32);
        // empty name gives no beats
        make_short(0, 0);
        send_bytes(32);

        // five full slots overrun the name store
        send_slots(5, 13, 0);
        send_short_file();
        // sequence number zero stores nothing
        make_slot(LFN_LAST_FLAG, 13);
        send_bytes(32);
        send_short_file();
        // early terminator inside a slot
        send_slots(2, 4, 0);
        send_short_file();

        // deleted, label and dot entries drop only the first stored character and the slot count
        send_slots(2, 9, 0);
        make_plain(BYTE_DELETED, ATTR_LFN);
        send_bytes(32);
        make_slot(8'h02, 13);
        send_bytes(32);
        send_short_file();
        make_slot(8'h01, 13);
        send_bytes(32);
        send_short_file();
        send_slots(1, 6, 0);
        make_plain(name_byte(1), ATTR_VOLUME | 8'h10);
        send_bytes(32);
        send_short_file();
        send_slots(1, 6, 0);
        make_plain(CHAR_DOT, 8'h10);
        send_bytes(32);
        send_short_file();

        // slot count saturates
        make_slot(LFN_LAST_FLAG, 0);
        send_bytes(32);
        for (k = 0; k < 21; k++) begin
            make_slot(8'h00, 3);
            send_bytes(32);
        end
        send_short_file();

        // restart in the middle of an entry
        fill_noise();
        send_bytes(10);
        restart_next = 1'b1;
        send_short_file();
        // end of directory, trailing bytes dropped, then a new directory
        send_dir_end(20);
        send_slots(1, 13, 0);
        send_short_file();

        rand_start = entries_sent;
        while (entries_sent < rand_start + RAND_ENTRIES) begin
            calm = (entries_sent >= rand_start + 40) && (entries_sent < rand_start + 80);
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_slots($urandom_range(1, 5), $urandom_range(1, 13), $urandom_range(7) == 0);
                send_short_file();
            end else if (pick < 65) begin
                send_short_file();
            end else if (pick < 72) begin
                make_plain(BYTE_DELETED, $urandom_range(255));
                send_bytes(32);
            end else if (pick < 78) begin
                make_plain(name_byte(1), $urandom_range(255) | ATTR_VOLUME);
                if (ent[11] == ATTR_LFN) ent[11] = ATTR_VOLUME;
                send_bytes(32);
            end else if (pick < 82) begin
                make_plain(CHAR_DOT, $urandom_range(255) & ~ATTR_VOLUME);
                send_bytes(32);
            end else if (pick < 88) begin
                fill_noise();
                send_bytes(32);
            end else if (pick < 93) begin
                send_dir_end($urandom_range(0, 40));
            end else if (pick < 97) begin
                fill_noise();
                send_bytes($urandom_range(1, 31));
                restart_next = 1'b1;
            end else begin
                restart_next = 1'b1;
                send_short_file();
            end
        end
        calm = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
